// File: rtl/core/pshs_pkg.sv
// ----------------------------------------------------------------------------
// pshs_pkg: shared types and constants of the pair sum hash search
// Key and index widths, the index counter limit and the index and key types.
// ----------------------------------------------------------------------------
package pshs_pkg;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned IdxW  = 7;
  localparam logic [IdxW-1:0] IdxMax = {IdxW{1'b1}};

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [KeyW-1:0]   key_t;
  typedef logic [KeyW:0]     wide_key_t;

endpackage

// File: rtl/core/pair_sum_hash_search_top.sv
// ----------------------------------------------------------------------------
// pair_sum_hash_search_top: streaming two-sum search over a CAM table
// Pipeline: the input register captures the request, search/update then
//   loads the result register.
// Throughput: one request per cycle, no bubbles, while the result side does not
//   stall; the CAM search and table update are combinational between the two registers.
// Reset: clears entry valid bits, item counter, solved latch, target and
//   both pipeline valids; key and index entries are left as they are.
// ----------------------------------------------------------------------------
module pair_sum_hash_search_top import pshs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // target register write
  input  logic                 target_sum_we_i,
  input  logic signed [31:0]   target_sum_i,
  // request channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   value_i,
  input  logic                 first_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [6:0]           earlier_index_o,
  output logic [6:0]           later_index_o,
  output logic                 table_full_o
);

  // --------------------------------------------------------------------------
  // Target register
  // --------------------------------------------------------------------------
  key_t target_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (target_sum_we_i) begin
      target_q <= target_sum_i;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: stage 1 holds the request, the result register follows.
  // Stage 1 moves on whenever the result register is empty or being drained.
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  key_t s1_value_q;
  logic s1_first_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (advance || !s1_valid_q) begin
      s1_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_value_q <= value_i;
      s1_first_q <= first_i;
    end
  end

  // --------------------------------------------------------------------------
  // Table state: one CAM row per entry
  // --------------------------------------------------------------------------
  key_t                   key_q   [TABLE_DEPTH];
  idx_t                   pos_q   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_q;
  idx_t                   count_q;
  logic                   solved_q;

  // Working view of the state: a first request sees an empty table
  logic [TABLE_DEPTH-1:0] valid_eff;
  idx_t                   count_eff;
  logic                   solved_eff;
  logic                   work;      // request is processed (not ignored)
  idx_t                   count_new;
  wide_key_t              search_key;

  assign valid_eff  = s1_first_q ? '0 : valid_q;
  assign count_eff  = s1_first_q ? '0 : count_q;
  assign solved_eff = s1_first_q ? 1'b0 : solved_q;
  assign work       = !solved_eff;
  assign count_new  = (count_eff == IdxMax) ? count_eff : count_eff + idx_t'(1);

  // 33-bit difference, never wraps
  assign search_key = {target_q[KeyW-1], target_q} - {s1_value_q[KeyW-1], s1_value_q};

  // Parallel compares against every valid row
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] equal_vec;

  always_comb begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      hit_vec[i]   = valid_eff[i] && ({key_q[i][KeyW-1], key_q[i]} == search_key);
      equal_vec[i] = valid_eff[i] && (key_q[i] == s1_value_q);
    end
  end

  // Lowest-set-bit pick for hits and for free rows
  logic [TABLE_DEPTH-1:0] hit_first;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] free_first;

  assign hit_first  = hit_vec & (~hit_vec + TABLE_DEPTH'(1));
  assign free_vec   = ~valid_eff;
  assign free_first = free_vec & (~free_vec + TABLE_DEPTH'(1));

  logic any_hit;
  logic any_equal;
  logic any_free;

  assign any_hit   = |hit_vec;
  assign any_equal = |equal_vec;
  assign any_free  = |free_vec;

  // Stored index of the matching row (one-hot AND-OR select)
  idx_t hit_pos;

  always_comb begin
    hit_pos = '0;
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      hit_pos = hit_pos | (pos_q[i] & {IdxW{hit_first[i]}});
    end
  end

  // Row written on a miss: the equal-key row if any, else the lowest free one
  logic [TABLE_DEPTH-1:0] wr_vec;
  logic                   do_insert;
  logic                   drop;

  assign do_insert = work && !any_hit;
  assign wr_vec    = do_insert ? (any_equal ? equal_vec : free_first) : '0;
  assign drop      = do_insert && !any_equal && !any_free;

  // --------------------------------------------------------------------------
  // State update when stage 1 retires
  // --------------------------------------------------------------------------
  logic retire;
  assign retire = s1_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      count_q  <= '0;
      solved_q <= 1'b0;
    end else if (retire) begin
      valid_q  <= valid_eff | wr_vec;
      count_q  <= work ? count_new : count_eff;
      solved_q <= solved_eff || (work && any_hit);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned i = 0; i < TABLE_DEPTH; i++) begin
      if (retire && wr_vec[i]) begin
        key_q[i] <= s1_value_q;
        pos_q[i] <= count_new;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic found_q;
  idx_t earlier_q;
  idx_t later_q;
  logic full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      found_q   <= work && any_hit;
      earlier_q <= (work && any_hit) ? hit_pos : '0;
      later_q   <= (work && any_hit) ? count_new : '0;
      full_q    <= drop;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign earlier_index_o = earlier_q;
  assign later_index_o   = later_q;
  assign table_full_o    = full_q;

endmodule

// File: rtl/core/pshs_checker.sv
// ----------------------------------------------------------------------------
// pshs_checker: port-level checks of the pair sum hash search
// Result field consistency, stall behavior and result hold under stall.
// ----------------------------------------------------------------------------
module pshs_checker import pshs_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_stall_o,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic            found_o,
  input logic [IdxW-1:0] earlier_index_o,
  input logic [IdxW-1:0] later_index_o,
  input logic            table_full_o
);

  // a pair carries two nonzero indices, the earlier one not after the later
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      earlier_index_o != '0 && later_index_o != '0 && earlier_index_o <= later_index_o)
    else $error("pshs: bad pair indices");

  // no pair, no indices
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> earlier_index_o == '0 && later_index_o == '0)
    else $error("pshs: indices without a pair");

  // a hit never also drops an insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && table_full_o))
    else $error("pshs: found and table_full together");

  // request side only stalls when a result is waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("pshs: request stall without result backpressure");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) &&
      $stable(earlier_index_o) && $stable(later_index_o) && $stable(table_full_o))
    else $error("pshs: stalled result changed");

endmodule

bind pair_sum_hash_search_top pshs_checker u_pshs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .found_o         (found_o),
  .earlier_index_o (earlier_index_o),
  .later_index_o   (later_index_o),
  .table_full_o    (table_full_o)
);

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the pair sum hash search
// Drives a table of directed requests, then random arrays (solvable pairs,
// small-value noise, long arrays that can fill the table and saturate the index),
// and checks every result against typed values or an in-bench model of the search table.
// ----------------------------------------------------------------------------
module tb_top;
  import pshs_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned PHASE_ITEMS = 210;
  localparam int unsigned NUM_PHASES  = 8;
  localparam int unsigned QUIET_AFTER = PHASE_ITEMS * NUM_PHASES - 150;
  localparam int unsigned NUM_ROWS    = 19;

  typedef struct packed {
    logic found;
    idx_t earlier;
    idx_t later;
    logic full;
  } pair_result_t;

  // One directed request; an optional target write goes ahead of it and the
  // result is typed in only where it is obvious.
  typedef struct packed {
    logic         wr_tgt;
    key_t         tgt;
    key_t         value;
    logic         first;
    logic         typed;
    pair_result_t res;
  } dir_row_t;

  localparam pair_result_t NO_PAIR = '0;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic target_sum_we_i;
  logic signed [31:0] target_sum_i;
  logic in_valid_i;
  logic in_stall_o;
  logic signed [31:0] value_i;
  logic first_i;
  logic out_valid_o;
  logic out_stall_i;
  logic found_o;
  logic [6:0] earlier_index_o;
  logic [6:0] later_index_o;
  logic table_full_o;

  pair_sum_hash_search_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .target_sum_we_i(target_sum_we_i),
    .target_sum_i   (target_sum_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .first_i        (first_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .earlier_index_o(earlier_index_o),
    .later_index_o  (later_index_o),
    .table_full_o   (table_full_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model of the search table
  // --------------------------------------------------------------------------
  key_t stored_key [TABLE_DEPTH];
  idx_t stored_pos [TABLE_DEPTH];
  logic entry_used [TABLE_DEPTH];
  idx_t elem_count;
  logic pair_solved;
  key_t cur_target;

  pair_result_t expected_results [$];

  int unsigned items_offered;
  int unsigned results_checked;
  int unsigned err_count;
  int unsigned n_found, n_full, n_sat, n_ignored, n_overwrite, n_wide_key;
  bit          quiet;

  // Generous hard stop; the slowest legal run is well under a tenth of this.
  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still pending", $time, expected_results.size());
    $display("status: fail");
    $finish;
  end

  function automatic void clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) entry_used[i] = 1'b0;
    elem_count  = '0;
    pair_solved = 1'b0;
  endfunction

  // Search for target - value at 33 bits; on a miss insert or refresh the
  // value. Returns the result this request must produce.
  function automatic pair_result_t search_and_update(input key_t v, input logic f);
    pair_result_t res;
    wide_key_t    want;
    int           hit, slot;
    res  = NO_PAIR;
    hit  = -1;
    slot = -1;
    if (f) clear_table();
    if (pair_solved) begin
      n_ignored++;
      return res;
    end
    if (elem_count != IdxMax) elem_count++;
    else n_sat++;
    want = {cur_target[31], cur_target} - {v[31], v};
    if (want[32] != want[31]) n_wide_key++;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (hit < 0 && entry_used[i] && {stored_key[i][31], stored_key[i]} == want) hit = i;
    if (hit >= 0) begin
      res.found   = 1'b1;
      res.earlier = stored_pos[hit];
      res.later   = elem_count;
      pair_solved = 1'b1;
      n_found++;
      return res;
    end
    // equal value first, then lowest free entry
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot < 0 && entry_used[i] && stored_key[i] == v) slot = i;
    if (slot >= 0) n_overwrite++;
    for (int i = 0; i < TABLE_DEPTH; i++)
      if (slot < 0 && !entry_used[i]) slot = i;
    if (slot >= 0) begin
      stored_key[slot] = v;
      stored_pos[slot] = elem_count;
      entry_used[slot] = 1'b1;
    end else begin
      res.full = 1'b1;
      n_full++;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------

  // Offer one request and hold it until taken; valid stays high afterwards
  // so back-to-back requests need no bubble.
  task automatic offer_request(input key_t v, input logic f, input logic typed,
                               input pair_result_t typed_res);
    pair_result_t predicted;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    first_i    <= f;
    do @(posedge clk_i); while (in_stall_o);
    predicted = search_and_update(v, f);
    expected_results.push_back(typed ? typed_res : predicted);
    items_offered++;
    if (items_offered - n_ignored >= QUIET_AFTER) quiet = 1'b1;
  endtask

  // Target changes only with the pipe empty; every request yields a result,
  // so an empty expectation queue means the block is idle.
  task automatic write_target(input key_t t);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    target_sum_we_i <= 1'b1;
    target_sum_i    <= t;
    @(posedge clk_i);
    target_sum_we_i <= 1'b0;
    cur_target = t;
  endtask

  // One random array. Kinds: a planted pair after a random prefix, with a
  // few trailing requests that the block must ignore; small-value noise with
  // stray first flags; a long array with repeats that can fill the table and
  // run the index counter into saturation.
  task automatic play_array();
    key_t        arr [$];
    key_t        w, v;
    wide_key_t   k;
    int unsigned kind, len;
    bit          noisy;
    kind  = $urandom_range(0, 9);
    noisy = 1'b0;
    if (kind <= 5) begin
      len = $urandom_range(1, 20);
      repeat (len) arr.push_back($urandom);
      w = $urandom;
      k = {cur_target[31], cur_target} - {w[31], w};
      if (k[32] == k[31]) v = k[31:0];
      else begin
        v = '0;
        w = cur_target;
      end
      arr[$urandom_range(0, len - 1)] = v;
      arr.push_back(w);
      repeat ($urandom_range(0, 3)) arr.push_back($urandom);
    end else if (kind <= 7) begin
      noisy = 1'b1;
      len   = $urandom_range(1, 30);
      repeat (len) arr.push_back(key_t'(int'($urandom_range(0, 16)) - 8));
    end else begin
      len = $urandom_range(66, 150);
      for (int i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(0, 5) == 0) arr.push_back(arr[$urandom_range(0, i - 1)]);
        else arr.push_back($urandom);
      end
    end
    foreach (arr[i])
      offer_request(arr[i], (i == 0) || (noisy && $urandom_range(0, 9) == 0), 1'b0, NO_PAIR);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall bursts plus one long hold-off to back the
  // pipe up into the request port.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    bit          long_done;
    hold        = 0;
    long_done   = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!long_done && results_checked >= 500) begin
        long_done = 1'b1;
        hold      = 200;
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        hold = $urandom_range(1, 10) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pair_result_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, found %0b earlier %0d later %0d full %0b",
                 $time, found_o, earlier_index_o, later_index_o, table_full_o);
        err_count++;
      end else begin
        exp_r = expected_results.pop_front();
        check_field("found", int'(exp_r.found), int'(found_o));
        check_field("earlier_index", int'(exp_r.earlier), int'(earlier_index_o));
        check_field("later_index", int'(exp_r.later), int'(later_index_o));
        check_field("table_full", int'(exp_r.full), int'(table_full_o));
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  dir_row_t dir_table [NUM_ROWS] = '{
    // no first after reset, target still at its reset value 0
    '{1'b0, 32'h0, 32'd5, 1'b0, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd3, 1'b0, 1'b1, NO_PAIR},
    // repeated value only refreshes its index to 3
    '{1'b0, 32'h0, 32'd3, 1'b0, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'hFFFF_FFFD, 1'b0, 1'b1, '{1'b1, 7'd3, 7'd4, 1'b0}},
    // solved: ignored until the next first
    '{1'b0, 32'h0, 32'hFFFF_FFFB, 1'b0, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd0, 1'b1, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd0, 1'b0, 1'b1, '{1'b1, 7'd1, 7'd2, 1'b0}},
    // most positive target; max - min does not fit 32 bits and must miss
    '{1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'h7FFF_FFFF, 1'b0, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd0, 1'b0, 1'b1, '{1'b1, 7'd2, 7'd3, 1'b0}},
    // most negative target, key below 32-bit range
    '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'h8000_0000, 1'b0, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd0, 1'b0, 1'b1, '{1'b1, 7'd2, 7'd3, 1'b0}},
    '{1'b0, 32'h0, 32'd1, 1'b0, 1'b1, NO_PAIR},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, NO_PAIR},
    '{1'b0, 32'h0, 32'd0, 1'b0, 1'b1, '{1'b1, 7'd1, 7'd2, 1'b0}},
    // alternating bit patterns, left to the model
    '{1'b0, 32'h0, 32'h5555_5555, 1'b1, 1'b0, NO_PAIR},
    '{1'b0, 32'h0, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_PAIR},
    '{1'b0, 32'h0, 32'd12345, 1'b1, 1'b0, NO_PAIR}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    key_t        phase_tgt;
    int unsigned guard;
    rst_ni          = 1'b0;
    target_sum_we_i = 1'b0;
    target_sum_i    = '0;
    in_valid_i      = 1'b0;
    value_i         = '0;
    first_i         = 1'b0;
    cur_target      = '0;
    clear_table();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_table[r]) begin
      if (dir_table[r].wr_tgt) write_target(dir_table[r].tgt);
      offer_request(dir_table[r].value, dir_table[r].first, dir_table[r].typed,
                    dir_table[r].res);
    end

    // Random phases, each under its own target; small targets let the
    // small-value noise arrays hit pairs often.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p % 4)
        0:       phase_tgt = key_t'(int'($urandom_range(0, 16)) - 8);
        1:       phase_tgt = (p == 1) ? 32'h7FFF_FFFF : 32'h0;
        2:       phase_tgt = (p == 2) ? 32'h8000_0000 : $urandom;
        default: phase_tgt = $urandom;
      endcase
      write_target(phase_tgt);
      while (items_offered - n_ignored < NUM_ROWS + (p + 1) * PHASE_ITEMS) play_array();
    end
    in_valid_i <= 1'b0;

    guard = 0;
    while (expected_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());

    $display("Covered %0d requests, %0d results checked: %0d pairs, %0d ignored after a pair",
             items_offered, results_checked, n_found, n_ignored);
    $display("  %0d refreshed values, %0d dropped on a full table, %0d at index limit, %0d wide keys",
             n_overwrite, n_full, n_sat, n_wide_key);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
